/* hdl/sc1asc_pkg.sv */
// Types, key codes and character ROM shared by the scancode decoder.
`default_nettype none
package sc1asc_pkg;

	localparam logic [7:0] PREFIX_EXT  = 8'hE0;
	localparam logic [6:0] KEY_CTRL    = 7'h1D;
	localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT  = 7'h36;
	localparam logic [6:0] KEY_ALT     = 7'h38;
	localparam logic [6:0] KEY_FSLASH  = 7'h35;
	localparam logic [6:0] KEY_CAPS    = 7'h3A;
	localparam logic [6:0] KEY_NUM     = 7'h45;
	localparam logic [6:0] KEY_SCROLL  = 7'h46;
	localparam logic [6:0] CHAR_LC_A   = 7'h61;
	localparam logic [6:0] CHAR_LC_Z   = 7'h7A;

	typedef struct packed {
		logic       valid;
		logic       prefix;
		logic       ext;
		logic       release_k;
		logic [6:0] key;
	} key_op_t;

	typedef struct packed {
		logic       valid;
		logic       hit;
		logic       ext;
		logic       release_k;
		logic [6:0] key;
		logic [1:0] new_val;
	} kmap_s1_t;

	typedef struct packed {
		logic       char_valid;
		logic [6:0] ascii_char;
		logic       led_update;
		logic [2:0] led_bits;
		logic       shift_active;
		logic       ctrl_active;
		logic       alt_active;
	} result_t;

	function automatic logic [6:0] rom_plain(input logic [6:0] k);
		logic [6:0] c;
		case (k)
			7'h01: c = 7'h1B; 7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33;
			7'h05: c = 7'h34; 7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37;
			7'h09: c = 7'h38; 7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D;
			7'h0D: c = 7'h3D; 7'h0E: c = 7'h08; 7'h0F: c = 7'h09;
			7'h10: c = 7'h71; 7'h11: c = 7'h77; 7'h12: c = 7'h65; 7'h13: c = 7'h72;
			7'h14: c = 7'h74; 7'h15: c = 7'h79; 7'h16: c = 7'h75; 7'h17: c = 7'h69;
			7'h18: c = 7'h6F; 7'h19: c = 7'h70; 7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D;
			7'h1C: c = 7'h0A; 7'h1E: c = 7'h61; 7'h1F: c = 7'h73;
			7'h20: c = 7'h64; 7'h21: c = 7'h66; 7'h22: c = 7'h67; 7'h23: c = 7'h68;
			7'h24: c = 7'h6A; 7'h25: c = 7'h6B; 7'h26: c = 7'h6C; 7'h27: c = 7'h3B;
			7'h28: c = 7'h27; 7'h29: c = 7'h60; 7'h2B: c = 7'h5C; 7'h2C: c = 7'h7A;
			7'h2D: c = 7'h78; 7'h2E: c = 7'h63; 7'h2F: c = 7'h76;
			7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D; 7'h33: c = 7'h2C;
			7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
			7'h47: c = 7'h37; 7'h48: c = 7'h38; 7'h49: c = 7'h39; 7'h4A: c = 7'h2D;
			7'h4B: c = 7'h34; 7'h4C: c = 7'h35; 7'h4D: c = 7'h36; 7'h4E: c = 7'h2B;
			7'h4F: c = 7'h31; 7'h50: c = 7'h32; 7'h51: c = 7'h33; 7'h52: c = 7'h30;
			7'h53: c = 7'h2E;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] rom_shift(input logic [6:0] k);
		logic [6:0] c;
		case (k)
			7'h01: c = 7'h1B; 7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23;
			7'h05: c = 7'h24; 7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26;
			7'h09: c = 7'h2A; 7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F;
			7'h0D: c = 7'h2B; 7'h0E: c = 7'h08; 7'h0F: c = 7'h09;
			7'h10: c = 7'h51; 7'h11: c = 7'h57; 7'h12: c = 7'h45; 7'h13: c = 7'h52;
			7'h14: c = 7'h54; 7'h15: c = 7'h59; 7'h16: c = 7'h55; 7'h17: c = 7'h49;
			7'h18: c = 7'h4F; 7'h19: c = 7'h50; 7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D;
			7'h1C: c = 7'h0A; 7'h1E: c = 7'h41; 7'h1F: c = 7'h53;
			7'h20: c = 7'h44; 7'h21: c = 7'h46; 7'h22: c = 7'h47; 7'h23: c = 7'h48;
			7'h24: c = 7'h4A; 7'h25: c = 7'h4B; 7'h26: c = 7'h4C; 7'h27: c = 7'h3A;
			7'h28: c = 7'h22; 7'h29: c = 7'h7E; 7'h2B: c = 7'h7C; 7'h2C: c = 7'h5A;
			7'h2D: c = 7'h58; 7'h2E: c = 7'h43; 7'h2F: c = 7'h56;
			7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D; 7'h33: c = 7'h3C;
			7'h34: c = 7'h3E; 7'h35: c = 7'h3F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
			7'h4A: c = 7'h2D; 7'h4E: c = 7'h2B; 7'h53: c = 7'h7F;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

/* hdl/sc1asc_keymap.sv */
// Key-down map memory with read-modify-write and write-to-read forwarding.
`default_nettype none
module sc1asc_keymap #(
	parameter int NUM_KEYS = 96
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire sc1asc_pkg::key_op_t  req,
	output sc1asc_pkg::kmap_s1_t      s1
);
	localparam int AW = $clog2(NUM_KEYS);

	logic [1:0]          mem [NUM_KEYS];
	logic [NUM_KEYS-1:0] ent_vld_q;

	logic          req_hit;
	logic [AW-1:0] raddr;
	logic          re;

	sc1asc_pkg::key_op_t op_s1;
	logic          hit_s1;
	logic [1:0]    rdata_s1;
	logic          rvld_s1;
	logic          fwd_s1;
	logic [1:0]    fwd_data_s1;

	logic [1:0]    old_val;
	logic [1:0]    mask;
	logic [1:0]    new_val;
	logic          we;
	logic [AW-1:0] waddr;

	assign req_hit = req.valid && !req.prefix && ({1'b0, req.key} < 8'(NUM_KEYS));
	assign raddr   = req.key[AW-1:0];
	assign re      = req_hit;

	assign old_val = fwd_s1 ? fwd_data_s1 : (rvld_s1 ? rdata_s1 : 2'b00);
	assign mask    = op_s1.ext ? 2'b10 : 2'b01;
	assign new_val = op_s1.release_k ? (old_val & ~mask) : (old_val | mask);
	assign we      = op_s1.valid && hit_s1;
	assign waddr   = op_s1.key[AW-1:0];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= new_val;
		if (re)
			rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		rvld_s1     <= ent_vld_q[raddr];
		fwd_data_s1 <= new_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			op_s1     <= '0;
			hit_s1    <= 1'b0;
			fwd_s1    <= 1'b0;
		end else begin
			if (we)
				ent_vld_q[waddr] <= 1'b1;
			op_s1  <= req;
			hit_s1 <= req_hit;
			fwd_s1 <= we && re && (waddr == raddr);
		end
	end

	always_comb begin
		s1.valid     = op_s1.valid;
		s1.hit       = hit_s1;
		s1.ext       = op_s1.ext;
		s1.release_k = op_s1.release_k;
		s1.key       = op_s1.key;
		s1.new_val   = new_val;
	end
endmodule
`default_nettype wire

/* hdl/sc1asc_decode.sv */
// Lock and modifier state, character lookup and result word assembly.
`default_nettype none
module sc1asc_decode (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire sc1asc_pkg::kmap_s1_t s1,
	output logic                      push,
	output sc1asc_pkg::result_t       res
);
	logic       caps_q, num_q, scroll_q;
	logic       shl_q, shr_q;
	logic [1:0] ctrl_q, alt_q;

	logic       wr, press;
	logic       caps_n, num_n, scroll_n;
	logic       shl_n, shr_n;
	logic [1:0] ctrl_n, alt_n;
	logic       is_lock;
	logic [6:0] plain, shifted, ch;
	logic       shift;

	always_comb begin
		wr    = s1.valid && s1.hit;
		press = wr && !s1.release_k;

		num_n    = num_q    ^ (press && s1.key == sc1asc_pkg::KEY_NUM);
		caps_n   = caps_q   ^ (press && s1.key == sc1asc_pkg::KEY_CAPS);
		scroll_n = scroll_q ^ (press && s1.key == sc1asc_pkg::KEY_SCROLL);
		is_lock  = s1.key == sc1asc_pkg::KEY_NUM || s1.key == sc1asc_pkg::KEY_CAPS ||
		           s1.key == sc1asc_pkg::KEY_SCROLL;

		shl_n  = (wr && s1.key == sc1asc_pkg::KEY_LSHIFT) ? s1.new_val[0] : shl_q;
		shr_n  = (wr && s1.key == sc1asc_pkg::KEY_RSHIFT) ? s1.new_val[0] : shr_q;
		ctrl_n = (wr && s1.key == sc1asc_pkg::KEY_CTRL)   ? s1.new_val    : ctrl_q;
		alt_n  = (wr && s1.key == sc1asc_pkg::KEY_ALT)    ? s1.new_val    : alt_q;

		plain   = sc1asc_pkg::rom_plain(s1.key);
		shifted = sc1asc_pkg::rom_shift(s1.key);
		shift   = (caps_n && plain >= sc1asc_pkg::CHAR_LC_A && plain <= sc1asc_pkg::CHAR_LC_Z)
		          ^ (shl_n || shr_n);
		if (!press)
			ch = 7'h00;
		else if (s1.ext && s1.key != sc1asc_pkg::KEY_FSLASH)
			ch = shifted;
		else
			ch = shift ? shifted : plain;

		push             = s1.valid;
		res.char_valid   = ch != 7'h00;
		res.ascii_char   = ch;
		res.led_update   = press && is_lock;
		res.led_bits     = {caps_n, num_n, scroll_n};
		res.shift_active = shl_n || shr_n;
		res.ctrl_active  = |ctrl_n;
		res.alt_active   = |alt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caps_q   <= 1'b0;
			num_q    <= 1'b0;
			scroll_q <= 1'b0;
			shl_q    <= 1'b0;
			shr_q    <= 1'b0;
			ctrl_q   <= 2'b00;
			alt_q    <= 2'b00;
		end else begin
			caps_q   <= caps_n;
			num_q    <= num_n;
			scroll_q <= scroll_n;
			shl_q    <= shl_n;
			shr_q    <= shr_n;
			ctrl_q   <= ctrl_n;
			alt_q    <= alt_n;
		end
	end
endmodule
`default_nettype wire

/* hdl/sc1asc_outbuf.sv */
// Two-word result buffer with room tracking for words still in flight.
`default_nettype none
module sc1asc_outbuf (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire sc1asc_pkg::result_t din,
	input  wire                      pend,
	output logic                     full,
	output logic                     dout_valid,
	input  wire                      dout_stall,
	output sc1asc_pkg::result_t      dout
);
	sc1asc_pkg::result_t buf_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] occ_q;
	logic       pop;

	assign pop        = (occ_q != 2'd0) && !dout_stall;
	assign dout_valid = occ_q != 2'd0;
	assign dout       = buf_q[rd_ptr_q];
	assign full       = ((occ_q == 2'd2) || (occ_q == 2'd1 && pend)) && !pop;

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			occ_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			occ_q <= occ_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

/* hdl/scancode_set1_to_ascii.sv */
// Top level of the PS/2 set-1 scancode to ASCII decoder.
// Input channel: scan_valid / scan_stall carry one scancode byte per word.
// Output channel: res_valid / res_stall carry one result word per input byte,
// in order, including prefix, release and out-of-range bytes.
// An accepted byte is registered in the key-map memory read stage, is decoded
// and is written into the result buffer. Throughput is one byte per cycle while
// scan_stall is low; the key-map memory does one read and one write per cycle,
// and a write to the entry being read is forwarded.
// When res_stall is held the two-word result buffer fills and scan_stall rises;
// scan_stall follows res_stall in the same cycle once the buffer is full.
// Reset clears the lock flags, the prefix flag, the modifier copies and the
// per-entry valid bits of the key map, so all keys read as released at once;
// no clearing pass is needed and the first byte may be taken straight away.
`default_nettype none
module scancode_set1_to_ascii #(
	parameter int NUM_KEYS = 96
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        scan_valid,
	output logic       scan_stall,
	input  wire  [7:0] scan_byte,
	output logic       res_valid,
	input  wire        res_stall,
	output logic       char_valid,
	output logic [6:0] ascii_char,
	output logic       led_update,
	output logic [2:0] led_bits,
	output logic       shift_active,
	output logic       ctrl_active,
	output logic       alt_active
);
	sc1asc_pkg::key_op_t  req;
	sc1asc_pkg::kmap_s1_t s1;
	sc1asc_pkg::result_t  res, dout;
	logic                 accept, push, full;
	logic                 ext_pending_q;

	assign scan_stall = full;
	assign accept     = scan_valid && !full;

	always_comb begin
		req.valid     = accept;
		req.prefix    = scan_byte == sc1asc_pkg::PREFIX_EXT;
		req.ext       = ext_pending_q;
		req.release_k = scan_byte[7];
		req.key       = scan_byte[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ext_pending_q <= 1'b0;
		else if (accept)
			ext_pending_q <= req.prefix;
	end

	sc1asc_keymap #(
		.NUM_KEYS(NUM_KEYS)
	) u_keymap (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.s1     (s1)
	);

	sc1asc_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.s1     (s1),
		.push   (push),
		.res    (res)
	);

	sc1asc_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.din        (res),
		.pend       (s1.valid),
		.full       (full),
		.dout_valid (res_valid),
		.dout_stall (res_stall),
		.dout       (dout)
	);

	assign char_valid   = dout.char_valid;
	assign ascii_char   = dout.ascii_char;
	assign led_update   = dout.led_update;
	assign led_bits     = dout.led_bits;
	assign shift_active = dout.shift_active;
	assign ctrl_active  = dout.ctrl_active;
	assign alt_active   = dout.alt_active;
endmodule
`default_nettype wire

/* tb/scancode_set1_to_ascii_tb.sv */
// Self-checking testbench for the set-1 scancode to ASCII decoder.
`timescale 1ns / 100ps
module scancode_set1_to_ascii_tb;

	localparam int KEY_COUNT  = 96;
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASE_LEN  = 370;
	localparam int HOLD_AT    = 300;
	localparam int HOLD_LEN   = 150;

	typedef enum logic [1:0] {
		PH_STEADY,
		PH_SRC_IDLE,
		PH_SINK_STALL,
		PH_BOTH
	} idle_phase_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       scan_valid = 1'b0;
	logic [7:0] scan_byte = 8'h00;
	logic       res_stall = 1'b0;
	logic       scan_stall;
	logic       res_valid;
	logic       char_valid;
	logic [6:0] ascii_char;
	logic       led_update;
	logic [2:0] led_bits;
	logic       shift_active;
	logic       ctrl_active;
	logic       alt_active;

	idle_phase_t idle_phase = PH_STEADY;

	logic [7:0]          pending_scans [$];
	sc1asc_pkg::result_t predicted_results [$];

	logic [6:0] plain_col [KEY_COUNT];
	logic [6:0] shift_col [KEY_COUNT];
	logic [1:0] held_map [KEY_COUNT];
	logic       caps_on = 1'b0;
	logic       num_on = 1'b0;
	logic       scroll_on = 1'b0;
	logic       ext_armed = 1'b0;

	int err_count = 0;
	int results_seen = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	scancode_set1_to_ascii #(.NUM_KEYS(KEY_COUNT)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.scan_valid(scan_valid),
		.scan_stall(scan_stall),
		.scan_byte(scan_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.char_valid(char_valid),
		.ascii_char(ascii_char),
		.led_update(led_update),
		.led_bits(led_bits),
		.shift_active(shift_active),
		.ctrl_active(ctrl_active),
		.alt_active(alt_active)
	);

	always #6 clk = ~clk;

	// rows given as strings, leftmost char at the lowest key number
	task automatic fill_keys(input int first, input int n, input logic [8*13-1:0] lo,
			input logic [8*13-1:0] hi);
		for (int i = 0; i < n; i++) begin
			plain_col[first+i] = lo[8*(n-1-i) +: 7];
			shift_col[first+i] = hi[8*(n-1-i) +: 7];
		end
	endtask

	task automatic build_keymaps();
		for (int i = 0; i < KEY_COUNT; i++) begin
			plain_col[i] = 7'h00;
			shift_col[i] = 7'h00;
			held_map[i]  = 2'b00;
		end
		fill_keys(8'h02, 12, "1234567890-=", "!@#$%^&*()_+");
		fill_keys(8'h10, 12, "qwertyuiop[]", "QWERTYUIOP{}");
		fill_keys(8'h1E, 11, "asdfghjkl;'", "ASDFGHJKL:\"");
		fill_keys(8'h2B, 11, "\\zxcvbnm,./", "|ZXCVBNM<>?");
		fill_keys(8'h47, 13, "789-456+1230.", 104'h0);
		plain_col[8'h01] = 7'h1B; shift_col[8'h01] = 7'h1B;
		plain_col[8'h0E] = 7'h08; shift_col[8'h0E] = 7'h08;
		plain_col[8'h0F] = 7'h09; shift_col[8'h0F] = 7'h09;
		plain_col[8'h1C] = 7'h0A; shift_col[8'h1C] = 7'h0A;
		plain_col[8'h29] = 7'h60; shift_col[8'h29] = 7'h7E;
		plain_col[8'h37] = 7'h2A; shift_col[8'h37] = 7'h2A;
		plain_col[8'h39] = 7'h20; shift_col[8'h39] = 7'h20;
		shift_col[8'h4A] = 7'h2D;
		shift_col[8'h4E] = 7'h2B;
		shift_col[8'h53] = 7'h7F;
	endtask

	task automatic decode_scan(input logic [7:0] b);
		sc1asc_pkg::result_t r;
		logic [6:0] k;
		logic [6:0] ch;
		logic [1:0] m;
		logic       ext;
		logic       shifted;
		r = '0;
		k = b[6:0];
		ch = 7'h00;
		if (b == sc1asc_pkg::PREFIX_EXT) begin
			ext_armed = 1'b1;
		end else begin
			ext = ext_armed;
			ext_armed = 1'b0;
			m = ext ? 2'b10 : 2'b01;
			if (k < KEY_COUNT) begin
				if (b[7]) begin
					held_map[k] = held_map[k] & ~m;
				end else begin
					held_map[k] = held_map[k] | m;
					if (k == sc1asc_pkg::KEY_NUM) begin
						num_on = ~num_on;
						r.led_update = 1'b1;
					end else if (k == sc1asc_pkg::KEY_CAPS) begin
						caps_on = ~caps_on;
						r.led_update = 1'b1;
					end else if (k == sc1asc_pkg::KEY_SCROLL) begin
						scroll_on = ~scroll_on;
						r.led_update = 1'b1;
					end
					shifted = caps_on && plain_col[k] >= sc1asc_pkg::CHAR_LC_A &&
					          plain_col[k] <= sc1asc_pkg::CHAR_LC_Z;
					if (held_map[sc1asc_pkg::KEY_LSHIFT][0] ||
					    held_map[sc1asc_pkg::KEY_RSHIFT][0])
						shifted = ~shifted;
					if (ext && k != sc1asc_pkg::KEY_FSLASH)
						ch = shift_col[k];
					else
						ch = shifted ? shift_col[k] : plain_col[k];
					r.char_valid = (ch != 7'h00);
					r.ascii_char = ch;
				end
			end
		end
		r.led_bits     = {caps_on, num_on, scroll_on};
		r.shift_active = held_map[sc1asc_pkg::KEY_LSHIFT][0] |
		                 held_map[sc1asc_pkg::KEY_RSHIFT][0];
		r.ctrl_active  = |held_map[sc1asc_pkg::KEY_CTRL];
		r.alt_active   = |held_map[sc1asc_pkg::KEY_ALT];
		predicted_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at word %0d: %s got %0h want %0h", results_seen, what, got, want);
		err_count++;
	endtask

	function automatic bit sender_idles();
		case (idle_phase)
			PH_SRC_IDLE: return $urandom_range(99) < 45;
			PH_BOTH:     return $urandom_range(99) < 7;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_phase)
			PH_SINK_STALL: return $urandom_range(99) < 45;
			PH_BOTH:       return $urandom_range(99) < 7;
			default:       return 1'b0;
		endcase
	endfunction

	task automatic push_key(input bit ext, input bit rel, input logic [6:0] k);
		if (ext)
			pending_scans.push_back(sc1asc_pkg::PREFIX_EXT);
		pending_scans.push_back({rel, k});
	endtask

	// mostly typing: press/release strokes, modifier holds and lock presses, plus raw noise
	task automatic queue_typing(input int n);
		int         sel;
		logic [6:0] k;
		bit         ext;
		while (pending_scans.size() < n) begin
			sel = $urandom_range(99);
			ext = ($urandom_range(7) == 0);
			if (sel < 10) begin
				pending_scans.push_back(8'($urandom_range(255)));
			end else if (sel < 20) begin
				case ($urandom_range(3))
					0: k = sc1asc_pkg::KEY_LSHIFT;
					1: k = sc1asc_pkg::KEY_RSHIFT;
					2: k = sc1asc_pkg::KEY_CTRL;
					default: k = sc1asc_pkg::KEY_ALT;
				endcase
				push_key(ext, 1'($urandom_range(1)), k);
			end else if (sel < 24) begin
				case ($urandom_range(2))
					0: k = sc1asc_pkg::KEY_CAPS;
					1: k = sc1asc_pkg::KEY_NUM;
					default: k = sc1asc_pkg::KEY_SCROLL;
				endcase
				push_key(ext, 1'b0, k);
			end else begin
				k = (sel < 28) ? 7'($urandom_range(96, 127)) : 7'($urandom_range(95));
				push_key(ext, 1'b0, k);
				if ($urandom_range(3) != 0)
					push_key(ext, 1'b1, k);
			end
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			scan_valid <= 1'b0;
			scan_byte  <= 8'h00;
		end else if (!scan_valid || !scan_stall) begin
			if (scan_valid)
				decode_scan(scan_byte);
			if (pending_scans.size() > 0 && !sender_idles()) begin
				scan_valid <= 1'b1;
				scan_byte  <= pending_scans.pop_front();
			end else begin
				scan_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		sc1asc_pkg::result_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("unexpected word", 1, 0);
				end else begin
					want = predicted_results.pop_front();
					if (char_valid !== want.char_valid)
						report_mismatch("char_valid", int'(char_valid),
							int'(want.char_valid));
					if (ascii_char !== want.ascii_char)
						report_mismatch("ascii_char", int'(ascii_char),
							int'(want.ascii_char));
					if (led_update !== want.led_update)
						report_mismatch("led_update", int'(led_update),
							int'(want.led_update));
					if (led_bits !== want.led_bits)
						report_mismatch("led_bits", int'(led_bits), int'(want.led_bits));
					if (shift_active !== want.shift_active)
						report_mismatch("shift_active", int'(shift_active),
							int'(want.shift_active));
					if (ctrl_active !== want.ctrl_active)
						report_mismatch("ctrl_active", int'(ctrl_active),
							int'(want.ctrl_active));
					if (alt_active !== want.alt_active)
						report_mismatch("alt_active", int'(alt_active),
							int'(want.alt_active));
				end
				results_seen++;
				if (results_seen == HOLD_AT)
					hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= receiver_stalls();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((scan_valid && !scan_stall) || (res_valid && !res_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("scancode_set1_to_ascii_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		build_keymaps();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero entry, out-of-range keys, prefixes, locks, caps vs shift, modifiers
		push_key(1'b0, 1'b0, 7'h00);
		push_key(1'b0, 1'b1, 7'h00);
		push_key(1'b0, 1'b0, 7'h7F);
		push_key(1'b0, 1'b1, 7'h7F);
		push_key(1'b0, 1'b0, 7'h60);
		pending_scans.push_back(sc1asc_pkg::PREFIX_EXT);
		push_key(1'b1, 1'b0, sc1asc_pkg::KEY_FSLASH);
		push_key(1'b1, 1'b1, sc1asc_pkg::KEY_FSLASH);
		push_key(1'b0, 1'b0, sc1asc_pkg::KEY_CAPS);
		push_key(1'b0, 1'b0, 7'h10);
		push_key(1'b0, 1'b0, 7'h02);
		push_key(1'b0, 1'b0, sc1asc_pkg::KEY_LSHIFT);
		push_key(1'b0, 1'b0, 7'h10);
		push_key(1'b0, 1'b0, 7'h02);
		push_key(1'b1, 1'b0, sc1asc_pkg::KEY_FSLASH);
		push_key(1'b0, 1'b1, sc1asc_pkg::KEY_LSHIFT);
		push_key(1'b0, 1'b0, sc1asc_pkg::KEY_NUM);
		push_key(1'b0, 1'b0, sc1asc_pkg::KEY_SCROLL);
		push_key(1'b1, 1'b0, sc1asc_pkg::KEY_CTRL);
		push_key(1'b1, 1'b0, sc1asc_pkg::KEY_ALT);
		push_key(1'b0, 1'b0, sc1asc_pkg::KEY_CTRL);
		push_key(1'b1, 1'b0, 7'h47);
		push_key(1'b1, 1'b0, 7'h53);
		push_key(1'b1, 1'b1, 7'h7F);
		push_key(1'b0, 1'b1, sc1asc_pkg::KEY_CTRL);
		push_key(1'b1, 1'b1, sc1asc_pkg::KEY_CTRL);
		push_key(1'b1, 1'b1, sc1asc_pkg::KEY_ALT);
		push_key(1'b0, 1'b0, sc1asc_pkg::KEY_RSHIFT);
		push_key(1'b0, 1'b0, 7'h5F);
		push_key(1'b0, 1'b1, sc1asc_pkg::KEY_RSHIFT);
		push_key(1'b0, 1'b0, sc1asc_pkg::KEY_CAPS);
		push_key(1'b1, 1'b0, sc1asc_pkg::KEY_NUM);

		queue_typing(pending_scans.size() + PHASE_LEN);
		while (pending_scans.size() > 0 || scan_valid)
			@(negedge clk);

		for (int p = PH_SRC_IDLE; p <= PH_BOTH; p++) begin
			idle_phase = idle_phase_t'(p);
			queue_typing(PHASE_LEN);
			while (pending_scans.size() > 0 || scan_valid)
				@(negedge clk);
		end

		while (predicted_results.size() > 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (err_count == 0)
			$display("scancode_set1_to_ascii_tb: clean");
		else
			$display("scancode_set1_to_ascii_tb: errors");
		$finish;
	end

endmodule
